[rtl/rbse_pkg.sv]
// ----------------------------------------------------------------------------
// rbse_pkg
// Shared types, constants and helper functions of the RRR bitmap encoder.
// ----------------------------------------------------------------------------
package rbse_pkg;

  localparam int MAX_BLOCK_BITS = 64;
  localparam int LENGTH_BITS    = 32;

  localparam int BW      = $clog2(MAX_BLOCK_BITS + 1);
  localparam int CHUNK_W = 64;
  localparam int OFF_W   = 61;
  localparam int OW_W    = 6;
  localparam int CNT_W   = LENGTH_BITS + 1;
  localparam int MPOS_W  = CNT_W + 1;
  localparam int SPC_W   = 16;
  localparam int CFG_W   = LENGTH_BITS;
  localparam int IDX_W   = 2;

  localparam int ROM_W     = 64;
  localparam int ROM_DEPTH = (MAX_BLOCK_BITS + 1) * (MAX_BLOCK_BITS + 1);
  localparam int ROM_AW    = $clog2(ROM_DEPTH);

  localparam logic [BW-1:0]    MIN_BLOCK   = BW'(2);
  localparam logic [BW-1:0]    TOP_BLOCK   = BW'(MAX_BLOCK_BITS);
  localparam logic [BW-1:0]    RST_BLOCK   = BW'(15);
  localparam logic [SPC_W-1:0] RST_SPACING = SPC_W'(256);
  localparam logic [CFG_W-1:0] RST_TOTAL   = CFG_W'(1);

  typedef enum logic [IDX_W-1:0] {
    REG_BLOCK_BITS     = 2'd0,
    REG_MARKER_SPACING = 2'd1,
    REG_TOTAL_BITS     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             block_valid;
    logic [BW-1:0]    block_class;
    logic [OFF_W-1:0] block_offset;
    logic [OW_W-1:0]  offset_width;
    logic [CNT_W-1:0] offset_position;
    logic             marker_valid;
    logic [CNT_W-1:0] marker_rank;
    logic [CNT_W-1:0] marker_offset;
    logic             last_result;
  } rec_t;

  typedef struct packed {
    logic init_step;
    logic take;
    logic bit_step;
    logic cls_read;
    logic cls_load;
    logic wid_step;
    logic record;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic full;
    logic wleft_zero;
    logic last_item;
    logic fill_zero;
    logic mk_pend;
    logic wid_done;
    logic held_valid;
    logic out_free;
  } sts_t;

  function automatic logic [BW-1:0] eff_block(logic [BW-1:0] b);
    logic [BW-1:0] r;
    r = b;
    if (b < MIN_BLOCK) r = MIN_BLOCK;
    if (b > TOP_BLOCK) r = TOP_BLOCK;
    return r;
  endfunction

  function automatic logic [SPC_W-1:0] eff_spacing(logic [BW-1:0] b, logic [SPC_W-1:0] s);
    return (s < SPC_W'(b)) ? SPC_W'(b) : s;
  endfunction

  function automatic logic [ROM_AW-1:0] rom_addr(logic [BW-1:0] n, logic [BW-1:0] k);
    return ROM_AW'(ROM_AW'(n) * ROM_AW'(MAX_BLOCK_BITS + 1)) + ROM_AW'(k);
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

endpackage

[rtl/rbse_stream_if.sv]
// ----------------------------------------------------------------------------
// rbse stream interfaces
// Valid/ready channels for bitmap chunks and for encoder records.
// ----------------------------------------------------------------------------
interface rbse_in_if;
  logic                        valid;
  logic                        ready;
  logic [rbse_pkg::CHUNK_W-1:0] chunk_bits;
  logic [rbse_pkg::BW-1:0]      chunk_width;
  logic                        last_chunk;

  modport source (output valid, chunk_bits, chunk_width, last_chunk, input ready);
  modport sink   (input valid, chunk_bits, chunk_width, last_chunk, output ready);
endinterface

interface rbse_out_if;
  logic                         valid;
  logic                         ready;
  logic                         block_valid;
  logic [rbse_pkg::BW-1:0]      block_class;
  logic [rbse_pkg::OFF_W-1:0]   block_offset;
  logic [rbse_pkg::OW_W-1:0]    offset_width;
  logic [rbse_pkg::CNT_W-1:0]   offset_position;
  logic                         marker_valid;
  logic [rbse_pkg::CNT_W-1:0]   marker_rank;
  logic [rbse_pkg::CNT_W-1:0]   marker_offset;
  logic                         last_result;

  modport source (output valid, block_valid, block_class, block_offset, offset_width,
                  offset_position, marker_valid, marker_rank, marker_offset, last_result,
                  input ready);
  modport sink   (input valid, block_valid, block_class, block_offset, offset_width,
                  offset_position, marker_valid, marker_rank, marker_offset, last_result,
                  output ready);
endinterface

[rtl/rbse_ram.sv]
// ----------------------------------------------------------------------------
// rbse_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rbse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/rbse_ctrl.sv]
// ----------------------------------------------------------------------------
// rbse_ctrl
// Sequencer: table build, bit walk, class lookup, width scan, record hand-off.
// ----------------------------------------------------------------------------
module rbse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rbse_pkg::sts_t sts,
  output rbse_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_BIT, ST_TAIL, ST_CLS, ST_CLSW, ST_WID, ST_REC, ST_END
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.init_done) state_next = ST_IDLE;
        else cmd.init_step = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        if (sts.full) state_next = ST_CLS;
        else if (sts.wleft_zero) state_next = ST_TAIL;
        else cmd.bit_step = 1'b1;
      end
      ST_TAIL: begin
        if (sts.last_item && !sts.fill_zero) state_next = ST_CLS;
        else if (sts.last_item && sts.mk_pend) state_next = ST_REC;
        else state_next = ST_END;
      end
      ST_CLS: begin
        cmd.cls_read = 1'b1;
        state_next   = ST_CLSW;
      end
      ST_CLSW: begin
        cmd.cls_load = 1'b1;
        state_next   = ST_WID;
      end
      ST_WID: begin
        if (sts.wid_done) state_next = ST_REC;
        else cmd.wid_step = 1'b1;
      end
      ST_REC: begin
        if (!sts.held_valid || sts.out_free) begin
          cmd.record = 1'b1;
          state_next = sts.full ? ST_BIT : ST_END;
        end
      end
      ST_END: begin
        if (!sts.held_valid || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/rbse_dp.sv]
// ----------------------------------------------------------------------------
// rbse_dp
// Datapath: configuration, stream counters, bit walk, offset ranking,
// width scan, record staging and output register.
// ----------------------------------------------------------------------------
module rbse_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rbse_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rbse_pkg::CFG_W-1:0]    cfg_data,
  input  logic [rbse_pkg::CHUNK_W-1:0]  chunk_bits,
  input  logic [rbse_pkg::BW-1:0]       chunk_width,
  input  logic                          last_chunk,
  output rbse_pkg::rec_t                out_rec,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  rbse_pkg::cmd_t                cmd,
  output rbse_pkg::sts_t                sts,
  output logic                          rom_we,
  output logic [rbse_pkg::ROM_AW-1:0]   rom_waddr,
  output logic [rbse_pkg::ROM_W-1:0]    rom_wdata,
  output logic [rbse_pkg::ROM_AW-1:0]   rom_raddr_a,
  output logic [rbse_pkg::ROM_AW-1:0]   rom_raddr_b,
  input  logic [rbse_pkg::ROM_W-1:0]    rom_rdata_a,
  input  logic [rbse_pkg::ROM_W-1:0]    rom_rdata_b
);

  // Configuration.
  logic [rbse_pkg::BW-1:0]    cfg_block;
  logic [rbse_pkg::SPC_W-1:0] cfg_spacing;
  logic [rbse_pkg::CFG_W-1:0] cfg_total;

  // Stream state.
  logic [rbse_pkg::BW-1:0]     fill;
  logic [rbse_pkg::BW-1:0]     ones;
  logic [rbse_pkg::ROM_W-1:0]  acc;
  logic [rbse_pkg::SPC_W-1:0]  cd;
  logic [rbse_pkg::BW-1:0]     cap;
  logic [rbse_pkg::CNT_W-1:0]  rank;
  logic [rbse_pkg::CNT_W-1:0]  cursor;
  logic [rbse_pkg::CFG_W-1:0]  consumed;
  logic [rbse_pkg::MPOS_W-1:0] mpos;

  // Current chunk.
  logic [rbse_pkg::CHUNK_W-1:0] vbits;
  logic [rbse_pkg::BW-1:0]      wleft;
  logic                         last_item;

  logic                        rd_pend;
  logic [rbse_pkg::ROM_W-1:0]  y;
  logic [rbse_pkg::OW_W-1:0]   ow;
  rbse_pkg::rec_t              held;
  rbse_pkg::rec_t              held_out;
  logic                        held_valid;

  // Table build counters.
  logic [rbse_pkg::BW-1:0] ifn;
  logic [rbse_pkg::BW-1:0] ifk;
  logic                    iph;
  logic                    init_done;

  logic [rbse_pkg::BW-1:0]     blk_b;
  logic [rbse_pkg::SPC_W-1:0]  spc_m;
  logic                        cfg_hit;
  logic [rbse_pkg::BW-1:0]     new_block;
  logic [rbse_pkg::SPC_W-1:0]  new_spacing;
  logic [rbse_pkg::SPC_W-1:0]  m_rst;
  logic                        bit_in;
  logic [rbse_pkg::BW-1:0]     ones_next;
  logic [rbse_pkg::MPOS_W-1:0] limit;
  logic                        mpos_ok;
  logic                        full;
  logic                        mk_hit;
  logic                        mk_pend;
  logic                        mv_blk;
  logic [rbse_pkg::SPC_W-1:0]  cd_after;
  logic [rbse_pkg::CNT_W-1:0]  rank_cls;
  logic [rbse_pkg::CNT_W-1:0]  rank_cap;
  rbse_pkg::rec_t              new_rec;
  logic                        bv;
  logic                        mv;
  logic [rbse_pkg::BW-1:0]     w_clip;
  logic [rbse_pkg::CFG_W-1:0]  remain;
  logic [rbse_pkg::BW-1:0]     w_take;
  logic                        push;
  logic                        srst;

  assign blk_b = rbse_pkg::eff_block(cfg_block);
  assign spc_m = rbse_pkg::eff_spacing(blk_b, cfg_spacing);

  assign cfg_hit = cfg_wr_en && (cfg_index == rbse_pkg::REG_BLOCK_BITS ||
                                 cfg_index == rbse_pkg::REG_MARKER_SPACING ||
                                 cfg_index == rbse_pkg::REG_TOTAL_BITS);
  assign new_block   = (cfg_index == rbse_pkg::REG_BLOCK_BITS) ?
                       cfg_data[rbse_pkg::BW-1:0] : cfg_block;
  assign new_spacing = (cfg_index == rbse_pkg::REG_MARKER_SPACING) ?
                       cfg_data[rbse_pkg::SPC_W-1:0] : cfg_spacing;
  assign m_rst = cfg_hit ?
                 rbse_pkg::eff_spacing(rbse_pkg::eff_block(new_block), new_spacing) : spc_m;

  assign bit_in    = vbits[0];
  assign ones_next = ones + rbse_pkg::BW'(bit_in);

  // A marker may still be emitted while its position stays within total + block - 1.
  assign limit   = {2'b00, cfg_total} + rbse_pkg::MPOS_W'(blk_b) - rbse_pkg::MPOS_W'(1);
  assign mpos_ok = (mpos <= limit);

  assign full     = (fill == blk_b);
  assign mk_hit   = (rbse_pkg::SPC_W'(blk_b) >= cd);
  assign mk_pend  = (cd < spc_m) && mpos_ok;
  assign mv_blk   = mk_hit && mpos_ok;
  assign cd_after = mk_hit ? (spc_m + cd - rbse_pkg::SPC_W'(blk_b))
                           : (cd - rbse_pkg::SPC_W'(blk_b));
  assign rank_cls = rbse_pkg::sat_add(rank, rbse_pkg::CNT_W'(ones));
  assign rank_cap = rbse_pkg::sat_add(rank, rbse_pkg::CNT_W'(cap));

  // A full block gives a block record; otherwise this is the final flush.
  always_comb begin
    bv = full || (fill != '0);
    mv = full ? mv_blk : mk_pend;
    new_rec.block_valid     = bv;
    new_rec.block_class     = bv ? ones : '0;
    new_rec.block_offset    = bv ? acc[rbse_pkg::OFF_W-1:0] : '0;
    new_rec.offset_width    = bv ? ow : '0;
    new_rec.offset_position = bv ? cursor : '0;
    new_rec.marker_valid    = mv;
    new_rec.marker_rank     = mv ? (full ? rank_cap : rank_cls) : '0;
    new_rec.marker_offset   = mv ? cursor : '0;
    new_rec.last_result     = 1'b0;
  end

  // The staged record leaves with last_result set when the chunk finishes.
  always_comb begin
    held_out             = held;
    held_out.last_result = cmd.finish;
  end

  assign w_clip = (chunk_width > rbse_pkg::TOP_BLOCK) ? rbse_pkg::TOP_BLOCK : chunk_width;
  assign remain = cfg_total - consumed;
  assign w_take = (remain < rbse_pkg::CFG_W'(w_clip)) ? remain[rbse_pkg::BW-1:0] : w_clip;

  assign push = (cmd.record || cmd.finish) && held_valid;
  assign srst = cfg_hit || (cmd.finish && last_item);

  // Table port: Pascal rows during the build, walk and class lookups later.
  assign rom_we      = cmd.init_step && iph;
  assign rom_waddr   = rbse_pkg::rom_addr(ifn, ifk);
  assign rom_wdata   = (ifk == '0) ? rbse_pkg::ROM_W'(1) :
                       (ifk > ifn) ? '0 : (rom_rdata_a + rom_rdata_b);
  assign rom_raddr_b = rbse_pkg::rom_addr(ifn - rbse_pkg::BW'(1), ifk);
  assign rom_raddr_a = cmd.init_step ?
                       rbse_pkg::rom_addr(ifn - rbse_pkg::BW'(1), ifk - rbse_pkg::BW'(1)) :
                       cmd.cls_read ? rbse_pkg::rom_addr(blk_b, ones) :
                       rbse_pkg::rom_addr(fill, ones_next);

  always_comb begin
    sts.init_done  = init_done;
    sts.full       = full;
    sts.wleft_zero = (wleft == '0);
    sts.last_item  = last_item;
    sts.fill_zero  = (fill == '0);
    sts.mk_pend    = mk_pend;
    sts.wid_done   = (y == '0);
    sts.held_valid = held_valid;
    sts.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_block   <= rbse_pkg::RST_BLOCK;
      cfg_spacing <= rbse_pkg::RST_SPACING;
      cfg_total   <= rbse_pkg::RST_TOTAL;
      fill        <= '0;
      ones        <= '0;
      acc         <= '0;
      cd          <= rbse_pkg::RST_SPACING;
      cap         <= '0;
      rank        <= '0;
      cursor      <= '0;
      consumed    <= '0;
      mpos        <= rbse_pkg::MPOS_W'(rbse_pkg::RST_SPACING);
      wleft       <= '0;
      last_item   <= 1'b0;
      rd_pend     <= 1'b0;
      ow          <= '0;
      held_valid  <= 1'b0;
      out_valid   <= 1'b0;
      ifn         <= '0;
      ifk         <= '0;
      iph         <= 1'b0;
      init_done   <= 1'b0;
    end else begin
      rd_pend <= cmd.bit_step && bit_in;
      if (rd_pend) begin
        acc <= acc + rom_rdata_a;
      end

      if (cmd.init_step) begin
        iph <= !iph;
        if (iph) begin
          if (ifk == rbse_pkg::TOP_BLOCK) begin
            ifk <= '0;
            if (ifn == rbse_pkg::TOP_BLOCK) init_done <= 1'b1;
            else ifn <= ifn + rbse_pkg::BW'(1);
          end else begin
            ifk <= ifk + rbse_pkg::BW'(1);
          end
        end
      end

      if (cmd.take) begin
        vbits     <= chunk_bits;
        wleft     <= w_take;
        last_item <= last_chunk;
        consumed  <= consumed + rbse_pkg::CFG_W'(w_take);
      end

      // One bitmap bit per step, lowest first, at block position fill.
      if (cmd.bit_step) begin
        vbits <= vbits >> 1;
        wleft <= wleft - rbse_pkg::BW'(1);
        fill  <= fill + rbse_pkg::BW'(1);
        ones  <= ones_next;
        if (rbse_pkg::SPC_W'(fill) == cd - rbse_pkg::SPC_W'(1)) begin
          cap <= ones_next;
        end
      end

      if (cmd.cls_load) begin
        y  <= rom_rdata_a - rbse_pkg::ROM_W'(1);
        ow <= '0;
      end

      if (cmd.wid_step) begin
        if (|y[rbse_pkg::ROM_W-1:8]) begin
          y  <= y >> 8;
          ow <= ow + rbse_pkg::OW_W'(8);
        end else begin
          y  <= y >> 1;
          ow <= ow + rbse_pkg::OW_W'(1);
        end
      end

      if (push) begin
        out_valid <= 1'b1;
        out_rec   <= held_out;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.record) begin
        held       <= new_rec;
        held_valid <= 1'b1;
        if (full) begin
          cursor <= rbse_pkg::sat_add(cursor, rbse_pkg::CNT_W'(ow));
          rank   <= rank_cls;
          mpos   <= mpos + (mv_blk ? rbse_pkg::MPOS_W'(spc_m) : '0);
          cd     <= cd_after;
          fill   <= '0;
          ones   <= '0;
          acc    <= '0;
        end
      end

      if (cmd.finish) begin
        held_valid <= 1'b0;
      end

      if (srst) begin
        fill     <= '0;
        ones     <= '0;
        acc      <= '0;
        cd       <= m_rst;
        rank     <= '0;
        cursor   <= '0;
        consumed <= '0;
        mpos     <= rbse_pkg::MPOS_W'(m_rst);
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          rbse_pkg::REG_BLOCK_BITS:     cfg_block   <= cfg_data[rbse_pkg::BW-1:0];
          rbse_pkg::REG_MARKER_SPACING: cfg_spacing <= cfg_data[rbse_pkg::SPC_W-1:0];
          rbse_pkg::REG_TOTAL_BITS:     cfg_total   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/rrr_bitmap_stream_encoder.sv]
// ----------------------------------------------------------------------------
// rrr_bitmap_stream_encoder
// Sequence: each chunk's bits are walked, then come the end check, the tail
// and the hand-off; each full block adds a class read and a width scan of at
// most 14 steps, and a flushed partial block adds a class read and its scan.
// Throughput: one chunk at a time; the next chunk is taken once all results of
// the current one are staged, so output stalls delay it.
// Reset: a build pass fills the binomial table, and no chunk is accepted until
// it finishes.
// ----------------------------------------------------------------------------
//
// The encoder packs bitmap bits, lowest first, into blocks of the configured
// size. Each bit is walked in its own cycle between block records: a set bit
// at position n that is the j-th one of its block adds C(n, j) to the block
// offset, the same rank as the top-down enumerative code. The binomial table
// lives in a RAM that the datapath builds row by row after reset.
//
// When a block is full its class is known, so C(block, class) is read and the
// offset width found by a short shift scan (eight bits a step while the value
// is large, then one). The record is staged in a holding register; the
// previous staged record moves to the output register at that point, and the
// final one of each chunk moves with its last_result flag set. The output
// register decouples the consumer from the walk.
//
// Marker bookkeeping keeps a countdown to the next marker bit, the ones seen
// below that bit within the current block, and the stream position of the
// next marker, compared against total + block - 1 to bound the marker count.
// A configuration write returns all stream state to its start values.
module rrr_bitmap_stream_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rbse_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rbse_pkg::CFG_W-1:0]  cfg_data,
  rbse_in_if.sink                     in_ch,
  rbse_out_if.source                  out_ch
);

  rbse_pkg::cmd_t cmd;
  rbse_pkg::sts_t sts;
  rbse_pkg::rec_t out_rec;

  logic                        rom_we;
  logic [rbse_pkg::ROM_AW-1:0] rom_waddr;
  logic [rbse_pkg::ROM_W-1:0]  rom_wdata;
  logic [rbse_pkg::ROM_AW-1:0] rom_raddr_a;
  logic [rbse_pkg::ROM_AW-1:0] rom_raddr_b;
  logic [rbse_pkg::ROM_W-1:0]  rom_rdata_a;
  logic [rbse_pkg::ROM_W-1:0]  rom_rdata_b;

  // Sequencer: decides which datapath step runs in each cycle.
  rbse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: counters, walk accumulator, width scan and result registers.
  rbse_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .chunk_bits  (in_ch.chunk_bits),
    .chunk_width (in_ch.chunk_width),
    .last_chunk  (in_ch.last_chunk),
    .out_rec     (out_rec),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts),
    .rom_we      (rom_we),
    .rom_waddr   (rom_waddr),
    .rom_wdata   (rom_wdata),
    .rom_raddr_a (rom_raddr_a),
    .rom_raddr_b (rom_raddr_b),
    .rom_rdata_a (rom_rdata_a),
    .rom_rdata_b (rom_rdata_b)
  );

  // Binomial table, indexed by n * (MAX_BLOCK_BITS + 1) + k.
  rbse_ram #(
    .WIDTH (rbse_pkg::ROM_W),
    .DEPTH (rbse_pkg::ROM_DEPTH)
  ) u_rom (
    .clk     (clk),
    .we      (rom_we),
    .waddr   (rom_waddr),
    .wdata   (rom_wdata),
    .raddr_a (rom_raddr_a),
    .rdata_a (rom_rdata_a),
    .raddr_b (rom_raddr_b),
    .rdata_b (rom_rdata_b)
  );

  // Each output beat carries one staged record.
  assign out_ch.block_valid     = out_rec.block_valid;
  assign out_ch.block_class     = out_rec.block_class;
  assign out_ch.block_offset    = out_rec.block_offset;
  assign out_ch.offset_width    = out_rec.offset_width;
  assign out_ch.offset_position = out_rec.offset_position;
  assign out_ch.marker_valid    = out_rec.marker_valid;
  assign out_ch.marker_rank     = out_rec.marker_rank;
  assign out_ch.marker_offset   = out_rec.marker_offset;
  assign out_ch.last_result     = out_rec.last_result;

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RRR bitmap stream encoder: drives chunk beats,
// predicts every block and marker record, and checks each result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rbse_pkg::*;

  localparam longint unsigned COUNT_MAX = 64'h1_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 150;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rbse_in_if  in_ch ();
  rbse_out_if out_ch ();

  rrr_bitmap_stream_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Shadow configuration and stream state of the encoder.
  bit [6:0]  sh_block;
  bit [15:0] sh_spacing;
  bit [31:0] sh_total;
  bit [63:0] acc_block;
  bit [63:0] acc_need;
  bit [63:0] ones_total;
  bit [63:0] offset_pos;
  bit [63:0] mark_count;
  bit [63:0] mark_issued;
  bit [63:0] block_count;
  bit [63:0] pascal [0:64][0:64];

  rec_t record_q[$];
  int   mismatches;
  int   chunks_sent;
  int   hold_cycles;
  bit   steady_sink;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous limit: well above the slowest legal run with full stalls.
  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int cur_block();
    if (sh_block < 2) return 2;
    if (sh_block > 64) return 64;
    return sh_block;
  endfunction

  function automatic int cur_spacing();
    int b;
    b = cur_block();
    return (sh_spacing < b) ? b : sh_spacing;
  endfunction

  function automatic bit [63:0] lowbits(bit [63:0] n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
    bit [63:0] s;
    s = a + b;
    return (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  // Bits needed to hold any offset below x: ceil(log2(x)), zero when x < 2.
  function automatic bit [5:0] code_width(bit [63:0] x);
    int n;
    n = 0;
    if (x < 2) return 0;
    x = x - 1;
    while (x != 0) begin
      n++;
      x = x >> 1;
    end
    return n[5:0];
  endfunction

  // Enumerative rank: top bit down, each set bit n with c ones left adds C(n,c).
  function automatic bit [60:0] class_rank(int b, int cls, bit [63:0] v);
    bit [63:0] acc;
    acc = 0;
    if (cls == 0 || cls >= b) return 0;
    for (int n = b - 1; n >= 0 && cls > 0; n--) begin
      if (v[n]) begin
        acc += pascal[n][cls];
        cls--;
      end
    end
    return acc[60:0];
  endfunction

  task automatic restart_stream();
    acc_block   = 0;
    acc_need    = cur_block();
    ones_total  = 0;
    offset_pos  = 0;
    mark_count  = cur_spacing();
    mark_issued = 0;
    block_count = 0;
  endtask

  // Works out every record one accepted chunk causes and queues them.
  task automatic predict_chunk(bit [63:0] data, bit [6:0] width, bit last);
    bit [63:0] b, m, t, limit, consumed, remain, w, v, need, blk, cls, extra, mr;
    bit [5:0]  ow;
    bit        mv, bv;
    rec_t      r;
    int        first;
    b = cur_block();
    m = cur_spacing();
    t = sh_total;
    limit = (t + b - 1) / m;
    consumed = block_count * b + (b - acc_need);
    remain = (consumed < t) ? t - consumed : 0;
    first = record_q.size();
    w = (width > 64) ? 64 : width;
    if (w > remain) w = remain;
    v = data & lowbits(w);
    while (acc_need <= w) begin
      need = acc_need;
      blk = acc_block | ((v & lowbits(need)) << (b - need));
      cls = $countones(blk);
      ow = code_width(pascal[b][cls]);
      mv = 1'b0;
      mr = 0;
      v = (need >= 64) ? 0 : (v >> need);
      w -= need;
      if (b >= mark_count) begin
        extra = b - mark_count;
        if (mark_issued < limit) begin
          mv = 1'b1;
          mr = sat_sum(ones_total, $countones(blk & lowbits(mark_count)));
          mark_issued++;
        end
        mark_count = m - extra;
      end else begin
        mark_count -= b;
      end
      r = '0;
      r.block_valid = 1'b1;
      r.block_class = cls[BW-1:0];
      r.block_offset = class_rank(b, cls, blk);
      r.offset_width = ow;
      r.offset_position = offset_pos[CNT_W-1:0];
      r.marker_valid = mv;
      r.marker_rank = mv ? mr[CNT_W-1:0] : '0;
      r.marker_offset = mv ? offset_pos[CNT_W-1:0] : '0;
      record_q.push_back(r);
      offset_pos = sat_sum(offset_pos, ow);
      ones_total = sat_sum(ones_total, cls);
      block_count = (block_count + 1) & 64'hFFFF_FFFF;
      acc_block = 0;
      acc_need = b;
    end
    acc_block |= (v & lowbits(acc_need)) << (b - acc_need);
    acc_need -= w;
    if (last) begin
      // Flush: a partial block if it holds bits, plus a pending final marker.
      r = '0;
      bv = (acc_need < b);
      if (bv) begin
        cls = $countones(acc_block);
        r.block_valid = 1'b1;
        r.block_class = cls[BW-1:0];
        r.block_offset = class_rank(b, cls, acc_block);
        r.offset_width = code_width(pascal[b][cls]);
        r.offset_position = offset_pos[CNT_W-1:0];
        ones_total = sat_sum(ones_total, cls);
      end
      mv = (mark_count < m) && (mark_issued < limit);
      if (mv) begin
        r.marker_valid = 1'b1;
        r.marker_rank = ones_total[CNT_W-1:0];
        r.marker_offset = offset_pos[CNT_W-1:0];
      end
      if (bv || mv) record_q.push_back(r);
      restart_stream();
    end
    if (record_q.size() > first) record_q[record_q.size() - 1].last_result = 1'b1;
  endtask

  // Offers one chunk beat after a random gap; valid stays high on a zero gap.
  task automatic send_chunk(bit [63:0] data, bit [6:0] width, bit last);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.chunk_bits <= data;
    in_ch.chunk_width <= width;
    in_ch.last_chunk <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_chunk(data, width, last);
    chunks_sent++;
  endtask

  // Lets the encoder drain: all records back, then enough cycles for a chunk
  // that makes no record to finish its walk.
  task automatic wait_drained();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One write per call; the enable drops for a cycle before the next write.
  task automatic write_reg(reg_idx_t idx, bit [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_BLOCK_BITS:     sh_block = value[6:0];
      REG_MARKER_SPACING: sh_spacing = value[15:0];
      default:            sh_total = value;
    endcase
    restart_stream();
    @(posedge clk);
  endtask

  task automatic configure(bit [31:0] blk, bit [31:0] spc, bit [31:0] tot);
    write_reg(REG_BLOCK_BITS, blk);
    write_reg(REG_MARKER_SPACING, spc);
    write_reg(REG_TOTAL_BITS, tot);
  endtask

  function automatic bit [63:0] rand_bits();
    bit [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: x = x & {$urandom, $urandom};
      1: x = x | {$urandom, $urandom};
      2: x = '1;
      3: x = '0;
      default: ;
    endcase
    return x;
  endfunction

  // Default registers: total length one, so only the first bit of each stream counts.
  task automatic test_reset_defaults();
    send_chunk(64'h1, 7'd64, 1'b0);
    send_chunk('1, 7'd20, 1'b1);
    send_chunk('1, 7'd1, 1'b1);
    wait_drained();
  endtask

  // Field extremes and the documented corner cases, one setting at a time.
  task automatic test_corner_cases();
    configure(64, 64, 32'hFFFF_FFFF);
    send_chunk('1, 7'd64, 1'b0);
    send_chunk('0, 7'd64, 1'b0);
    send_chunk(64'h8000_0000_0000_0001, 7'd127, 1'b0);   // width above 64
    send_chunk(64'h5555_AAAA_0F0F_F0F0, 7'd64, 1'b0);
    send_chunk('1, 7'd0, 1'b1);                          // zero width flush
    send_chunk('1, 7'd0, 1'b1);                          // nothing to flush
    wait_drained();
    configure(0, 0, 32'd37);                             // clamped block, spacing
    send_chunk(64'hDEAD_BEEF_1234_5678, 7'd30, 1'b0);
    send_chunk('1, 7'd64, 1'b1);                         // past total length
    wait_drained();
    configure(127, 65535, 32'hFFFF_FFFF);                // block clamped to top
    send_chunk('1, 7'd63, 1'b0);
    send_chunk('1, 7'd1, 1'b1);
    wait_drained();
    configure(9, 4, 32'd100);                            // spacing below block
    send_chunk(64'hF0F0_F0F0_F0F0_F0F0, 7'd40, 1'b0);
    wait_drained();
    // A register write mid-stream drops the partial block.
    write_reg(REG_TOTAL_BITS, 32'd20);
    send_chunk('1, 7'd64, 1'b0);
    send_chunk('1, 7'd5, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_streams(int budget);
    int stop;
    bit [31:0] blk, spc, tot;
    bit [6:0] w;
    int n;
    stop = chunks_sent + budget;
    while (chunks_sent < stop) begin
      case ($urandom_range(0, 3))
        0: blk = 2;
        1: blk = 64;
        default: blk = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 5))
        0: spc = $urandom_range(0, blk);
        1: spc = 65535;
        default: spc = $urandom_range(blk, blk * 4);
      endcase
      tot = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2000) : 32'hFFFF_FFFF;
      configure(blk, spc, tot);
      steady_sink = ($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = $urandom_range(65, 127);
          2: w = 64;
          default: w = $urandom_range(1, 64);
        endcase
        send_chunk(rand_bits(), w, i == n - 1);
      end
      steady_sink = 1'b0;
      wait_drained();
    end
  endtask

  // Tiny blocks make many records per chunk; a long sink stall backs them up.
  task automatic test_output_stall();
    configure(2, 2, 32'hFFFF_FFFF);
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send_chunk(rand_bits(), 7'd64, i == 11);
    wait_drained();
  endtask

  // Sink: random ready gaps, one long hold when asked, none in steady stretches.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = steady_sink ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: %s expected 0x%0h, got 0x%0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Every result beat is compared with the oldest predicted record.
  always @(posedge clk) begin
    rec_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (record_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%t: result beat with none expected", $realtime);
      end else begin
        e = record_q.pop_front();
        check_field("block_valid", e.block_valid, out_ch.block_valid);
        check_field("block_class", e.block_class, out_ch.block_class);
        check_field("block_offset", e.block_offset, out_ch.block_offset);
        check_field("offset_width", e.offset_width, out_ch.offset_width);
        check_field("offset_position", e.offset_position, out_ch.offset_position);
        check_field("marker_valid", e.marker_valid, out_ch.marker_valid);
        check_field("marker_rank", e.marker_rank, out_ch.marker_rank);
        check_field("marker_offset", e.marker_offset, out_ch.marker_offset);
        check_field("last_result", e.last_result, out_ch.last_result);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.chunk_bits = '0;
    in_ch.chunk_width = '0;
    in_ch.last_chunk = 1'b0;
    mismatches = 0;
    chunks_sent = 0;
    hold_cycles = 0;
    steady_sink = 1'b0;
    for (int n = 0; n <= 64; n++) begin
      for (int k = 0; k <= 64; k++) pascal[n][k] = 0;
      pascal[n][0] = 1;
      for (int k = 1; k <= n; k++)
        pascal[n][k] = pascal[n-1][k-1] + ((k < n) ? pascal[n-1][k] : 0);
    end
    sh_block = 15;
    sh_spacing = 256;
    sh_total = 1;
    restart_stream();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_corner_cases();
    test_output_stall();
    test_random_streams(330);

    if (record_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rbse_pkg.sv
rtl/rbse_stream_if.sv
rtl/rbse_ram.sv
rtl/rbse_ctrl.sv
rtl/rbse_dp.sv
rtl/rrr_bitmap_stream_encoder.sv
verif/tb.sv
